/* src/tlbb_pkg.sv */
// shared constants, types and helpers for the text line bounding box
package tlbb_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = CNT_W + 1;
  localparam int unsigned RED_W   = 8;
  localparam int unsigned IDX_W   = 1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MAX    = DIM_W'(MAX_DIM);

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] left_col;
    logic [CNT_W-1:0] right_col;
    logic [CNT_W-1:0] top_row;
    logic [CNT_W-1:0] bottom_row;
  } box_t;

  typedef struct packed {
    logic emit;
    box_t box;
  } track_res_t;

  // zero reads as one, anything past the maximum reads as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

endpackage

/* src/tlbb_if.sv */
// request, result and register write channels
interface tlbb_in_if import tlbb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RED_W-1:0] red_level;
  modport source (output valid, output red_level, input ready);
  modport sink   (input valid, input red_level, output ready);
endinterface

interface tlbb_out_if import tlbb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] left_col;
  logic [CNT_W-1:0] right_col;
  logic [CNT_W-1:0] top_row;
  logic [CNT_W-1:0] bottom_row;
  modport source (output valid, output left_col, output right_col, output top_row,
                  output bottom_row, input ready);
  modport sink   (input valid, input left_col, input right_col, input top_row,
                  input bottom_row, output ready);
endinterface

interface tlbb_cfg_if import tlbb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [DIM_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/tlbb_track.sv */
// raster position counters and running box update, one pixel per cycle while fire_i is high
module tlbb_track import tlbb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [RED_W-1:0] red_level_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  output track_res_t       res_o
);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic             open_q, open_d;
  logic             ink_q, ink_d;
  box_t             box_q, box_d;

  logic             is_ink;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             row_end, frame_end, emit;
  box_t             box_upd;
  logic             open_upd;

  always_comb begin
    is_ink    = (red_level_i == '0);
    w_eff     = clamp_dim(width_i);
    h_eff     = clamp_dim(height_i);
    row_end   = ({1'b0, col_q} + DIM_W'(1)) >= w_eff;
    frame_end = ({1'b0, row_q} + DIM_W'(1)) >= h_eff;

    box_upd  = box_q;
    open_upd = open_q;
    if (is_ink) begin
      if (!open_q) begin
        open_upd           = 1'b1;
        box_upd.left_col   = col_q;
        box_upd.right_col  = col_q;
        box_upd.top_row    = row_q;
        box_upd.bottom_row = row_q;
      end else begin
        if (col_q < box_q.left_col)   box_upd.left_col   = col_q;
        if (col_q > box_q.right_col)  box_upd.right_col  = col_q;
        if (row_q < box_q.top_row)    box_upd.top_row    = row_q;
        if (row_q > box_q.bottom_row) box_upd.bottom_row = row_q;
      end
    end

    // a blank row closes the open box
    emit = row_end && open_upd && !(ink_q || is_ink);

    col_d  = col_q;
    row_d  = row_q;
    ink_d  = ink_q || is_ink;
    open_d = open_upd;
    box_d  = box_upd;
    if (row_end) begin
      ink_d = 1'b0;
      col_d = '0;
      row_d = frame_end ? '0 : row_q + CNT_W'(1);
      // box left open at frame end is dropped
      if (emit || frame_end) begin
        open_d = 1'b0;
        box_d  = '0;
      end
    end else begin
      col_d = col_q + CNT_W'(1);
    end

    res_o.emit = fire_i && emit;
    res_o.box  = box_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      open_q <= 1'b0;
      ink_q  <= 1'b0;
      box_q  <= '0;
    end else if (fire_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      open_q <= open_d;
      ink_q  <= ink_d;
      box_q  <= box_d;
    end
  end

endmodule

/* src/text_line_bounding_box.sv */
// text line bounding box top level: config registers, tracker, result register
//
//   channel  dir  payload                                    handshake
//   in_i     in   red_level[7:0]                             valid/ready
//   out_o    out  left_col, right_col, top_row, bottom_row   valid/ready
//   cfg_i    in   index[0] (0 width, 1 height), data[12:0]   valid/ready
//
// one pixel request per cycle; the tracker update is a single compare stage
// a box leaves through a one-entry result register in the cycle after the
// pixel that ends its blank row; input stalls only while that register is
// full and not being taken. reset gives width 640, height 480, empty box.
module text_line_bounding_box import tlbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlbb_in_if.sink     in_i,
  tlbb_out_if.source  out_o,
  tlbb_cfg_if.sink    cfg_i
);

  logic [DIM_W-1:0] width_q, height_q;
  logic             out_valid_q;
  box_t             out_box_q;
  logic             fire;
  track_res_t       res;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign fire        = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tlbb_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .red_level_i (in_i.red_level),
    .width_i     (width_q),
    .height_i    (height_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      out_box_q <= res.box;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.left_col   = out_box_q.left_col;
  assign out_o.right_col  = out_box_q.right_col;
  assign out_o.top_row    = out_box_q.top_row;
  assign out_o.bottom_row = out_box_q.bottom_row;

endmodule
